// ===== sv/bmft_pkg.sv =====
// Package: shared types, constants and codes for the block-mapped flash translation.
package bmft_pkg;
  localparam int DATA_BLOCKS_DEF = 16;
  localparam int BLOCK_PAGES_DEF = 8;
  localparam int LSN_W = 7;
  localparam int CMD_W = 3;
  localparam int PAGE_W = 8;
  localparam int BLK_W = 5;
  localparam int LBN_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ = 3'd0,
    CMD_PROG = 3'd1,
    CMD_TAG = 3'd2,
    CMD_COPY = 3'd3,
    CMD_ERASE = 3'd4,
    CMD_UNMAP = 3'd5,
    CMD_NOFREE = 3'd6
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_DECIDE, S_TAG, S_PROG1, S_MOVE, S_MOVE_ER,
    S_M1, S_M1_ER, S_M2, S_M2_ER, S_SCAN, S_EMIT
  } state_t;

  typedef struct packed {
    logic latch;     // capture request
    logic emit;      // load output register
    cmd_t cmd;
    logic last;
    logic [1:0] dst_sel;   // 0 pbn,1 nb,2 spare
    logic [1:0] src_sel;
    logic use_page;        // page counter as page, else offset
    logic page_clr;
    logic page_inc;
    logic do_alloc;
    logic do_setbit;
    logic do_move_er;
    logic do_sp_clr;
    logic scan_clr;
    logic scan_inc;
    logic scan_set;
  } ctl_t;

  typedef struct packed {
    logic kind;
    logic out_range;
    logic mapped;
    logic written;
    logic have_free;
    logic page_is_off;
    logic page_end;
    logic scan_hit;
    logic scan_end;
    logic out_busy;
  } sts_t;
endpackage

// ===== sv/bmft_ctrl.sv =====
// Controller: sequences the commands for one request.
module bmft_ctrl import bmft_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    ctl = '0;
    ctl.cmd = CMD_READ;
    state_nxt = state_r;
    in_ready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!sts.out_busy) begin
          ctl.page_clr = 1'b1;
          if (sts.out_range) begin
            if (!sts.kind) begin
              ctl.emit = 1'b1; ctl.cmd = CMD_UNMAP; ctl.last = 1'b1;
            end
            state_nxt = S_IDLE;
          end else if (!sts.kind) begin
            ctl.emit = 1'b1; ctl.last = 1'b1;
            ctl.cmd = sts.mapped ? CMD_READ : CMD_UNMAP;
            state_nxt = S_IDLE;
          end else if (!sts.mapped) begin
            if (!sts.have_free) begin
              ctl.emit = 1'b1; ctl.cmd = CMD_NOFREE; ctl.last = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              ctl.do_alloc = 1'b1;
              state_nxt = S_TAG;
            end
          end else if (!sts.written) begin
            ctl.emit = 1'b1; ctl.cmd = CMD_PROG; ctl.last = 1'b1;
            ctl.do_setbit = 1'b1;
            state_nxt = S_IDLE;
          end else if (sts.have_free) begin
            state_nxt = S_MOVE;
          end else begin
            state_nxt = S_M1;
          end
        end
      end
      S_TAG: begin
        if (!sts.out_busy) begin
          ctl.emit = 1'b1; ctl.cmd = CMD_TAG; ctl.use_page = 1'b1;
          state_nxt = S_PROG1;
        end
      end
      S_PROG1: begin
        if (!sts.out_busy) begin
          ctl.emit = 1'b1; ctl.cmd = CMD_PROG; ctl.last = 1'b1;
          ctl.do_setbit = 1'b1; ctl.scan_clr = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          ctl.scan_set = 1'b1; state_nxt = S_IDLE;
        end else if (sts.scan_end) begin
          ctl.scan_set = 1'b1; state_nxt = S_IDLE;
        end else ctl.scan_inc = 1'b1;
      end
      S_MOVE, S_M1, S_M2: begin
        if (!sts.out_busy) begin
          ctl.emit = 1'b1; ctl.use_page = 1'b1; ctl.page_inc = 1'b1;
          ctl.dst_sel = (state_r == S_MOVE) ? 2'd1 : (state_r == S_M1) ? 2'd2 : 2'd0;
          ctl.src_sel = (state_r == S_M2) ? 2'd2 : 2'd0;
          ctl.cmd = (sts.page_is_off && state_r != S_M2) ? CMD_PROG : CMD_COPY;
          if (sts.page_end) begin
            ctl.page_clr = 1'b1;
            state_nxt = (state_r == S_MOVE) ? S_MOVE_ER :
                        (state_r == S_M1) ? S_M1_ER : S_M2_ER;
          end
        end
      end
      S_MOVE_ER, S_M1_ER, S_M2_ER: begin
        if (!sts.out_busy) begin
          ctl.emit = 1'b1; ctl.cmd = CMD_ERASE;
          ctl.dst_sel = (state_r == S_M2_ER) ? 2'd2 : 2'd0;
          ctl.last = (state_r != S_M1_ER);
          ctl.do_move_er = (state_r == S_MOVE_ER);
          ctl.do_sp_clr = (state_r == S_M2_ER);
          state_nxt = (state_r == S_M1_ER) ? S_M2 : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> !sts.out_busy) else $error("emit while output full");
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.latch |=> !in_ready) else $error("accepted while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !ctl.emit) else $error("emit during scan");
endmodule

// ===== sv/bmft_dp.sv =====
// Datapath: maps, written-page bitmap, free pointer and output register.
module bmft_dp import bmft_pkg::*; #(
  parameter int DATA_BLOCKS = DATA_BLOCKS_DEF,
  parameter int BLOCK_PAGES = BLOCK_PAGES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_kind,
  input  logic [LSN_W-1:0] in_lsn,
  input  ctl_t ctl,
  output sts_t sts,
  output logic out_valid,
  input  logic out_ready,
  output logic [CMD_W-1:0] out_cmd,
  output logic [PAGE_W-1:0] out_page_addr,
  output logic [PAGE_W-1:0] out_source_page_addr,
  output logic [BLK_W-1:0] out_block_addr,
  output logic [LBN_W-1:0] out_lbn_tag,
  output logic [LSN_W-1:0] out_lsn_tag,
  output logic out_last
);
  localparam int BW = $clog2(DATA_BLOCKS + 1);
  localparam int IW = $clog2(DATA_BLOCKS);
  localparam int PW = $clog2(BLOCK_PAGES);
  localparam int LW = LSN_W;
  localparam int RS = 17;
  localparam logic [RS-1:0] RM = RS'((2**RS + BLOCK_PAGES - 1) / BLOCK_PAGES);

  logic [BW-1:0] bmap_r [DATA_BLOCKS];
  logic [DATA_BLOCKS-1:0] mvalid_r, rvalid_r;
  logic [BLOCK_PAGES-1:0] pw_r [DATA_BLOCKS+1];
  logic [BW-1:0] free_r, scan_r, pbn_r;
  logic [PW-1:0] page_r, off_r;
  logic [LW-1:0] lsn_r, lbn_r;
  logic kind_r, mapped_r;
  logic [BLOCK_PAGES-1:0] pwcur_r;
  logic ov_r;

  wire [LW+RS-1:0] lbn_prod = (LW+RS)'(in_lsn) * (LW+RS)'(RM);
  wire [LW-1:0] lbn_w = lbn_prod[LW+RS-1:RS];
  wire [LW-1:0] lbn_base = lbn_r * LW'(BLOCK_PAGES);
  wire [LW-1:0] off_w = lsn_r - lbn_base;
  wire oor = (lbn_r >= LW'(DATA_BLOCKS));
  wire [IW-1:0] lidx = oor ? '0 : lbn_r[IW-1:0];
  wire [BW-1:0] nb = free_r;
  wire [BW-1:0] sp = BW'(DATA_BLOCKS);

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      kind_r <= in_kind;
      lsn_r <= in_lsn;
      lbn_r <= lbn_w;
    end
    off_r <= off_w[PW-1:0];
    mapped_r <= !oor && mvalid_r[lidx];
    if (ctl.do_alloc) pbn_r <= free_r;
    else pbn_r <= bmap_r[lidx];
    pwcur_r <= pw_r[bmap_r[lidx]];
  end

  always_ff @(posedge clk) begin
    if (ctl.page_clr) page_r <= '0;
    else if (ctl.page_inc) page_r <= page_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvalid_r <= '0; rvalid_r <= '0; free_r <= '0; scan_r <= '0;
      for (int i = 0; i <= DATA_BLOCKS; i++) pw_r[i] <= '0;
    end else begin
      if (ctl.do_alloc) begin
        bmap_r[lidx] <= free_r; mvalid_r[lidx] <= 1'b1;
        rvalid_r[free_r[IW-1:0]] <= 1'b1;
      end
      if (ctl.do_setbit) pw_r[pbn_r][off_r] <= 1'b1;
      if (ctl.do_move_er) begin
        bmap_r[lidx] <= nb; rvalid_r[pbn_r[IW-1:0]] <= 1'b0; rvalid_r[nb[IW-1:0]] <= 1'b1;
        pw_r[nb] <= pw_r[pbn_r]; pw_r[pbn_r] <= '0; free_r <= pbn_r;
      end
      if (ctl.do_sp_clr) pw_r[DATA_BLOCKS] <= '0;
      if (ctl.scan_clr) scan_r <= '0;
      else if (ctl.scan_inc) scan_r <= scan_r + 1'b1;
      if (ctl.scan_set) free_r <= sts.scan_hit ? scan_r : sp;
    end
  end

  function automatic logic [PAGE_W-1:0] addr(input logic [BW-1:0] b, input logic [PW-1:0] p);
    logic [PAGE_W+BW-1:0] a;
    a = (PAGE_W+BW)'(b) * (PAGE_W+BW)'(BLOCK_PAGES) + (PAGE_W+BW)'(p);
    return a[PAGE_W-1:0];
  endfunction

  logic [BW-1:0] dst, src;
  logic [PW-1:0] pg;
  always_comb begin
    case (ctl.dst_sel)
      2'd1: dst = nb;
      2'd2: dst = sp;
      default: dst = pbn_r;
    endcase
    case (ctl.src_sel)
      2'd2: src = sp;
      default: src = pbn_r;
    endcase
    pg = ctl.use_page ? page_r : off_r;
  end

  always_comb begin
    sts.kind = kind_r;
    sts.out_range = oor;
    sts.mapped = mapped_r;
    sts.written = pwcur_r[off_r];
    sts.have_free = (free_r < sp);
    sts.page_is_off = (page_r == off_r);
    sts.page_end = (page_r == PW'(BLOCK_PAGES - 1));
    sts.scan_hit = (scan_r < sp) && !rvalid_r[scan_r[IW-1:0]];
    sts.scan_end = (scan_r >= sp - 1'b1);
    sts.out_busy = ov_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (ctl.emit) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_cmd <= ctl.cmd;
      out_last <= ctl.last;
      out_page_addr <= '0; out_source_page_addr <= '0; out_block_addr <= '0;
      out_lbn_tag <= '0; out_lsn_tag <= '0;
      case (ctl.cmd)
        CMD_READ: out_page_addr <= addr(pbn_r, off_r);
        CMD_TAG: begin
          out_page_addr <= addr(dst, '0); out_lbn_tag <= lbn_r[LBN_W-1:0];
        end
        CMD_PROG: begin
          out_page_addr <= addr(dst, pg); out_lbn_tag <= lbn_r[LBN_W-1:0];
          out_lsn_tag <= lsn_r;
        end
        CMD_COPY: begin
          out_page_addr <= addr(dst, pg); out_source_page_addr <= addr(src, pg);
        end
        CMD_ERASE: out_block_addr <= BLK_W'(dst);
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(out_cmd)) else $error("output lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.do_alloc |-> free_r < sp) else $error("alloc without free block");
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.do_move_er |-> free_r != pbn_r) else $error("move into own block");
endmodule

// ===== sv/block_mapped_flash_translation.sv =====
// Top level: block-mapped flash translation layer.
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_ready | kind, lsn
//   out_    | output    | out_valid/out_ready | cmd, addresses, tags, last
// After its transfer a request passes a lookup state, then a decide state that
// issues a one-command answer itself; later commands follow one per cycle unless stalled.
// A first write adds a free-block scan over the reverse map after its program command.
// A merge issues 2*BLOCK_PAGES+2 commands, one per cycle unless stalled, via the output register.
// Synchronous active-low reset clears the map valid bits and bitmap at once.
// A stalled output holds the sequencer in place.
module block_mapped_flash_translation import bmft_pkg::*; #(
  parameter int DATA_BLOCKS = DATA_BLOCKS_DEF,
  parameter int BLOCK_PAGES = BLOCK_PAGES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_kind,
  input  logic [LSN_W-1:0] in_lsn,
  output logic out_valid,
  input  logic out_ready,
  output logic [CMD_W-1:0] out_cmd,
  output logic [PAGE_W-1:0] out_page_addr,
  output logic [PAGE_W-1:0] out_source_page_addr,
  output logic [BLK_W-1:0] out_block_addr,
  output logic [LBN_W-1:0] out_lbn_tag,
  output logic [LSN_W-1:0] out_lsn_tag,
  output logic out_last
);
  ctl_t ctl;
  sts_t sts;

  bmft_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .ctl(ctl)
  );

  bmft_dp #(.DATA_BLOCKS(DATA_BLOCKS), .BLOCK_PAGES(BLOCK_PAGES)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_kind(in_kind), .in_lsn(in_lsn),
    .ctl(ctl), .sts(sts), .out_valid(out_valid), .out_ready(out_ready),
    .out_cmd(out_cmd), .out_page_addr(out_page_addr),
    .out_source_page_addr(out_source_page_addr), .out_block_addr(out_block_addr),
    .out_lbn_tag(out_lbn_tag), .out_lsn_tag(out_lsn_tag), .out_last(out_last)
  );
endmodule

// ===== tb/block_mapped_flash_translation_test.sv =====
// Testbench for the block-mapped flash translation layer: directed and random requests.
module block_mapped_flash_translation_test;
  import bmft_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = DATA_BLOCKS_DEF;
  localparam int NPG = BLOCK_PAGES_DEF;
  localparam int SPARE = NBLK;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic kind;
    logic [LSN_W-1:0] lsn;
  } req_t;

  typedef struct packed {
    cmd_t cmd;
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] src;
    logic [BLK_W-1:0] blk;
    logic [LBN_W-1:0] lbn;
    logic [LSN_W-1:0] lsn;
    logic last;
  } flash_cmd_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic in_kind = 0;
  logic [LSN_W-1:0] in_lsn = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [CMD_W-1:0] out_cmd;
  logic [PAGE_W-1:0] out_page_addr, out_source_page_addr;
  logic [BLK_W-1:0] out_block_addr;
  logic [LBN_W-1:0] out_lbn_tag;
  logic [LSN_W-1:0] out_lsn_tag;
  logic out_last;

  block_mapped_flash_translation dut (.*);

  always #5 clk = ~clk;

  req_t pending_reqs[$];
  flash_cmd_t expected_cmds[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int received = 0;
  int hold_until_drained = 0;

  // predictor state
  logic [BLK_W-1:0] lmap[NBLK];
  logic lmap_ok[NBLK];
  logic rmap_ok[NBLK];
  int free_blk;
  logic [NPG-1:0] written[NBLK+1];

  function automatic logic [PAGE_W-1:0] paddr(int b, int p);
    return PAGE_W'(b * NPG + p);
  endfunction

  function automatic void push_cmd(cmd_t c, int page, int src, int blk, int lbn, int lsn);
    flash_cmd_t f;
    f.cmd = c;
    f.page = PAGE_W'(page);
    f.src = PAGE_W'(src);
    f.blk = BLK_W'(blk);
    f.lbn = LBN_W'(lbn);
    f.lsn = LSN_W'(lsn);
    f.last = 0;
    expected_cmds.push_back(f);
  endfunction

  function automatic void translate(req_t r);
    int lbn, off, pbn, nb;
    lbn = r.lsn / NPG;
    off = r.lsn % NPG;
    if (lbn >= NBLK) begin
      if (r.kind) return;
      push_cmd(CMD_UNMAP, 0, 0, 0, 0, 0);
    end else if (!r.kind) begin
      if (lmap_ok[lbn]) push_cmd(CMD_READ, paddr(lmap[lbn], off), 0, 0, 0, 0);
      else push_cmd(CMD_UNMAP, 0, 0, 0, 0, 0);
    end else if (!lmap_ok[lbn]) begin
      if (free_blk >= NBLK) begin
        push_cmd(CMD_NOFREE, 0, 0, 0, 0, 0);
      end else begin
        pbn = free_blk;
        lmap[lbn] = BLK_W'(pbn);
        lmap_ok[lbn] = 1;
        rmap_ok[pbn] = 1;
        free_blk = NBLK;
        for (int i = NBLK - 1; i >= 0; i--) if (!rmap_ok[i]) free_blk = i;
        push_cmd(CMD_TAG, paddr(pbn, 0), 0, 0, lbn, 0);
        push_cmd(CMD_PROG, paddr(pbn, off), 0, 0, lbn, r.lsn);
        written[pbn][off] = 1;
      end
    end else begin
      pbn = lmap[lbn];
      if (!written[pbn][off]) begin
        push_cmd(CMD_PROG, paddr(pbn, off), 0, 0, lbn, r.lsn);
        written[pbn][off] = 1;
      end else if (free_blk < NBLK) begin
        nb = free_blk;
        lmap[lbn] = BLK_W'(nb);
        rmap_ok[pbn] = 0;
        rmap_ok[nb] = 1;
        for (int i = 0; i < NPG; i++)
          if (i == off) push_cmd(CMD_PROG, paddr(nb, i), 0, 0, lbn, r.lsn);
          else push_cmd(CMD_COPY, paddr(nb, i), paddr(pbn, i), 0, 0, 0);
        push_cmd(CMD_ERASE, 0, 0, pbn, 0, 0);
        written[nb] = written[pbn];
        written[pbn] = '0;
        free_blk = pbn;
      end else begin
        for (int i = 0; i < NPG; i++)
          if (i == off) push_cmd(CMD_PROG, paddr(SPARE, i), 0, 0, lbn, r.lsn);
          else push_cmd(CMD_COPY, paddr(SPARE, i), paddr(pbn, i), 0, 0, 0);
        push_cmd(CMD_ERASE, 0, 0, pbn, 0, 0);
        for (int i = 0; i < NPG; i++)
          push_cmd(CMD_COPY, paddr(pbn, i), paddr(SPARE, i), 0, 0, 0);
        push_cmd(CMD_ERASE, 0, 0, SPARE, 0, 0);
        written[SPARE] = '0;
      end
    end
    expected_cmds[$].last = 1;
  endfunction

  function automatic void add_req(bit k, int lsn);
    req_t r;
    r.kind = k;
    r.lsn = LSN_W'(lsn);
    pending_reqs.push_back(r);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        translate({in_kind, in_lsn});
        sent <= sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 0;
        end else if (pending_reqs.size() > 0 && !(hold_until_drained != 0 && sent == 60 &&
                     expected_cmds.size() > 0)) begin
          req_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1;
          in_kind <= r.kind;
          in_lsn <= r.lsn;
          in_gap <= (cycles % 400 < 100) ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  int out_wait = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        received <= received + 1;
        if (expected_cmds.size() == 0) begin
          $error("unexpected command cmd=%0d page=%0d", out_cmd, out_page_addr);
          errors++;
        end else begin
          flash_cmd_t e;
          e = expected_cmds.pop_front();
          if (out_cmd !== e.cmd) begin
            $error("cmd: expected %0d actual %0d", e.cmd, out_cmd); errors++; end
          if (out_page_addr !== e.page) begin
            $error("page_addr: expected %0d actual %0d", e.page, out_page_addr); errors++; end
          if (out_source_page_addr !== e.src) begin
            $error("source_page_addr: expected %0d actual %0d", e.src,
                   out_source_page_addr); errors++; end
          if (out_block_addr !== e.blk) begin
            $error("block_addr: expected %0d actual %0d", e.blk, out_block_addr); errors++; end
          if (out_lbn_tag !== e.lbn) begin
            $error("lbn_tag: expected %0d actual %0d", e.lbn, out_lbn_tag); errors++; end
          if (out_lsn_tag !== e.lsn) begin
            $error("lsn_tag: expected %0d actual %0d", e.lsn, out_lsn_tag); errors++; end
          if (out_last !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, out_last); errors++; end
        end
      end
      if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if (out_valid && (cycles % 400 >= 100)) out_wait <= $urandom_range(0, 3);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NBLK; i++) begin
      lmap[i] = '0;
      lmap_ok[i] = 0;
      rmap_ok[i] = 0;
    end
    for (int i = 0; i <= NBLK; i++) written[i] = '0;
    free_blk = 0;

    // directed: unmapped read, first write, empty page, move, read, extremes
    add_req(0, 0);
    add_req(1, 0);
    add_req(1, 7);
    add_req(0, 7);
    add_req(1, 0);
    add_req(0, 0);
    add_req(1, 127);
    add_req(0, 127);
    add_req(1, 127);
    add_req(0, 85);
    // fill every block, then overwrites merge through the spare block
    for (int b = 0; b < NBLK; b++) add_req(1, b * NPG + 3);
    add_req(1, 42);
    add_req(1, 43);
    add_req(1, 43);
    add_req(0, 43);
    add_req(0, 126);
    // random: reads of any sector, reads and writes within the first four blocks
    for (int n = 0; n < 140; n++) begin
      if ($urandom_range(0, 3) == 0) add_req(0, $urandom_range(0, 127));
      else add_req($urandom_range(0, 1), $urandom_range(0, 3) * NPG + $urandom_range(0, 7));
    end
    hold_until_drained = 1;

    repeat (3) @(posedge clk);
    rst_n <= 1;
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_cmds.size() == 0);
    repeat (50) @(posedge clk);
    $display("Ran %0d requests producing %0d flash commands:", sent, received);
    $display("reads, first writes, moves, spare-block merges and full-map cases.");
    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/bmft_pkg.sv
sv/bmft_ctrl.sv
sv/bmft_dp.sv
sv/block_mapped_flash_translation.sv
tb/block_mapped_flash_translation_test.sv
